// ----- hw/rtl/egsp_pkg.sv -----
package egsp_pkg;

    localparam int PT_W  = 48;
    localparam int RAD_W = 37;
    localparam int IDX_W = 2;

    typedef logic [127:0] wide_t;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } egsp_in_t;

    typedef struct packed {
        logic signed [PT_W-1:0] surface_x;
        logic signed [PT_W-1:0] surface_y;
        logic signed [PT_W-1:0] surface_z;
        logic [1:0]             status;
    } egsp_out_t;

    // result status codes
    localparam logic [1:0] STAT_CONV   = 2'd0;
    localparam logic [1:0] STAT_LIMIT  = 2'd1;
    localparam logic [1:0] STAT_ORIGIN = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_RADIUS_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_RADIUS_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS_Z = 2'd2;

    localparam logic [RAD_W-1:0] RAD_MIN = 37'd65536;
    localparam logic [RAD_W-1:0] RAD_MAX = 37'h10_0000_0000;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [87:0] ONE_Q40   = 88'd1 << 40;
    localparam logic [87:0] EPS_Q40   = 88'd110;
    localparam logic [90:0] ALPHA_MAX = 91'd1 << 90;
    localparam logic [47:0] OUT_MAX   = 48'h7FFF_FFFF_FFFF;

    localparam wide_t LIM_126 = wide_t'(1) << 126;
    localparam wide_t LIM_125 = wide_t'(1) << 125;
    localparam wide_t LIM_90  = wide_t'(1) << 90;
    localparam wide_t LIM_62  = wide_t'(1) << 62;
    localparam wide_t SQ_TOP  = wide_t'(1) << 126;

    // fraction shifts of the divisions
    localparam logic [6:0] K_U2  = 7'd60;
    localparam logic [6:0] K_M2  = 7'd32;
    localparam logic [6:0] K_AM  = 7'd16;
    localparam logic [6:0] K_W   = 7'd40;
    localparam logic [6:0] K_G   = 7'd48;
    localparam logic [6:0] K_STP = 7'd87;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_ZERO, OP_MUL, OP_DIV, OP_SQRT, OP_DIFF, OP_PASS,
        OP_DENOM, OP_RESID, OP_UPDATE, OP_OUTAX, OP_PUSH
    } egsp_op_t;

    typedef enum logic [3:0] {
        J_R2, J_PR, J_P2, J_U2, J_M2, J_ROOT, J_LEN, J_MM, J_DL, J_AM,
        J_W, J_W2, J_G, J_STP, J_OM
    } egsp_job_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_R2, ST_PR, ST_P2, ST_U2, ST_M2, ST_ROOT, ST_LEN,
        ST_MM, ST_DIFF, ST_DL, ST_AM, ST_PASS, ST_DENOM, ST_W, ST_W2, ST_G,
        ST_RESID, ST_STEP, ST_UPDATE, ST_OMUL, ST_OWR, ST_PUSH
    } egsp_state_t;

    typedef struct packed {
        egsp_op_t   op;
        egsp_job_t  job;
        logic       start;
        logic [1:0] axis;
        logic [1:0] stat;
    } egsp_cmd_t;

    typedef struct packed {
        logic done;
        logic origin;
        logic conv;
        logic out_full;
    } egsp_sts_t;

endpackage

// ----- hw/rtl/egsp_mul.sv -----
module egsp_mul
    import egsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output wide_t       p
);

    logic [63:0] a_reg, a_next, b_reg, b_next;
    logic [63:0] part_reg, part_next;
    wide_t       acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [31:0] pa, pb;
    wide_t       addend;

    always_comb begin
        case (cnt_reg)
            3'd0:    begin pa = a_reg[31:0];  pb = b_reg[31:0];  end
            3'd1:    begin pa = a_reg[31:0];  pb = b_reg[63:32]; end
            3'd2:    begin pa = a_reg[63:32]; pb = b_reg[31:0];  end
            default: begin pa = a_reg[63:32]; pb = b_reg[63:32]; end
        endcase
        case (cnt_reg)
            3'd1:      addend = {64'd0, part_reg};
            3'd2, 3'd3: addend = {32'd0, part_reg, 32'd0};
            3'd4:      addend = {part_reg, 64'd0};
            default:   addend = '0;
        endcase

        a_next    = a_reg;
        b_next    = b_reg;
        part_next = part_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            part_next = pa * pb;
            acc_next  = acc_reg + addend;
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        part_reg <= part_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ----- hw/rtl/egsp_div.sv -----
module egsp_div
    import egsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  wide_t      n,
    input  logic [6:0] k,
    input  wide_t      d,
    input  wide_t      lim,
    output logic       done,
    output wide_t      q
);

    wide_t      n_reg, n_next, rem_reg, rem_next, q_reg, q_next;
    wide_t      d_reg, d_next, lim_reg, lim_next, res_reg, res_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next, done_reg, done_next, sat_reg, sat_next;
    wide_t      rem_sh;
    logic       ge, over;

    // one quotient bit per cycle: numerator bits first, then k zero bits
    always_comb begin
        rem_sh = {rem_reg[126:0], n_reg[127]};
        ge     = (rem_sh >= d_reg);
        over   = (q_reg > lim_reg);

        n_next    = n_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        lim_next  = lim_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        if (start) begin
            n_next    = n;
            d_next    = d;
            lim_next  = lim;
            rem_next  = '0;
            q_next    = '0;
            sat_next  = 1'b0;
            cnt_next  = 8'd128 + {1'b0, k};
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg != 8'd0) begin
                n_next   = {n_reg[126:0], 1'b0};
                rem_next = ge ? (rem_sh - d_reg) : rem_sh;
                q_next   = {q_reg[126:0], ge};
                sat_next = sat_reg | over;
                cnt_next = cnt_reg - 8'd1;
            end else begin
                // quotient only grows, so a sticky flag catches saturation
                res_next  = (sat_reg || over || d_reg == '0) ? lim_reg : q_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        lim_reg <= lim_next;
        res_reg <= res_next;
        cnt_reg <= cnt_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign q    = res_reg;

endmodule

// ----- hw/rtl/egsp_sqrt.sv -----
module egsp_sqrt
    import egsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  wide_t       n,
    output logic        done,
    output logic [63:0] r
);

    wide_t num_reg, num_next, res_reg, res_next, bit_reg, bit_next;
    logic  busy_reg, busy_next, done_reg, done_next;
    wide_t t;
    logic  ge;

    // two radicand bits per cycle
    always_comb begin
        t  = res_reg + bit_reg;
        ge = (num_reg >= t);

        num_next  = num_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = n;
            res_next  = '0;
            bit_next  = SQ_TOP;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (bit_reg != '0) begin
                num_next = ge ? (num_reg - t) : num_reg;
                res_next = ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
                bit_next = bit_reg >> 2;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign r    = res_reg[63:0];

endmodule

// ----- hw/rtl/egsp_datapath.sv -----
module egsp_datapath
    import egsp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [RAD_W-1:0] cfg_data,
    input  egsp_in_t         s_data,
    input  egsp_cmd_t        cmd,
    output egsp_sts_t        sts,
    output logic             m_valid,
    input  logic             m_ready,
    output egsp_out_t        m_data
);

    logic [RAD_W-1:0] rad_reg [3], rad_next [3];
    logic [47:0]      pm_reg [3], pm_next [3];
    logic [2:0]       pn_reg, pn_next;
    logic [RAD_W-1:0] rr_reg [3], rr_next [3];
    logic [72:0]      r2_reg [3], r2_next [3];
    logic [83:0]      pr_reg [3], pr_next [3];
    logic [62:0]      wm_reg [3], wm_next [3];
    logic [47:0]      work_reg [3], work_next [3];
    wide_t            tmp_reg, tmp_next, u2_reg, u2_next;
    wide_t            sp2_reg, sp2_next, su2_reg, su2_next, sm2_reg, sm2_next;
    wide_t            sw2_reg, sw2_next, g_reg, g_next;
    logic [63:0]      root_reg, root_next, len_reg, len_next, mm_reg, mm_next;
    logic [63:0]      diff_reg, diff_next;
    logic             aneg_reg, aneg_next, sneg_reg, sneg_next;
    logic [90:0]      am_reg, am_next, stp_reg, stp_next;
    logic [91:0]      e_reg, e_next;
    logic [87:0]      smag_reg, smag_next;
    egsp_out_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic [47:0]  pt [3];
    logic [1:0]   ax;
    logic [63:0]  mul_a, mul_b;
    wide_t        mul_p;
    logic         mul_done;
    wide_t        div_n, div_d, div_lim, div_q;
    logic [6:0]   div_k;
    logic         div_done;
    wide_t        sq_n;
    logic [63:0]  sq_r;
    logic         sq_done;
    logic [90:0]  r2_ext;
    logic [87:0]  sq40;
    logic [91:0]  am_w;
    logic [87:0]  o_mag;
    logic [47:0]  mag;

    assign pt[0] = s_data.point_x;
    assign pt[1] = s_data.point_y;
    assign pt[2] = s_data.point_z;
    assign ax    = cmd.axis;

    // operand routing for the shared units
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_n   = '0;
        div_k   = '0;
        div_d   = '0;
        div_lim = '0;
        sq_n    = '0;
        case (cmd.job)
            J_R2: begin mul_a = {27'd0, rr_reg[ax]}; mul_b = {27'd0, rr_reg[ax]}; end
            J_PR: begin mul_a = {16'd0, pm_reg[ax]}; mul_b = {27'd0, rr_reg[ax]}; end
            J_P2: begin mul_a = {16'd0, pm_reg[ax]}; mul_b = {16'd0, pm_reg[ax]}; end
            J_DL: begin mul_a = diff_reg; mul_b = len_reg; end
            J_W2: begin mul_a = {1'b0, wm_reg[ax]}; mul_b = {1'b0, wm_reg[ax]}; end
            J_OM: begin mul_a = {1'b0, wm_reg[ax]}; mul_b = {27'd0, rr_reg[ax]}; end
            J_U2: begin
                div_n = tmp_reg; div_k = K_U2; div_d = {55'd0, r2_reg[ax]}; div_lim = LIM_126;
            end
            J_M2: begin
                div_n = u2_reg; div_k = K_M2; div_d = {55'd0, r2_reg[ax]}; div_lim = LIM_126;
            end
            J_AM: begin
                div_n = tmp_reg; div_k = K_AM; div_d = {64'd0, mm_reg}; div_lim = LIM_90;
            end
            J_W: begin
                div_n = {44'd0, pr_reg[ax]}; div_k = K_W; div_d = {36'd0, e_reg};
                div_lim = LIM_62;
            end
            J_G: begin
                div_n = tmp_reg; div_k = K_G; div_d = {36'd0, e_reg}; div_lim = LIM_125;
            end
            J_STP: begin
                div_n = {40'd0, smag_reg}; div_k = K_STP; div_d = g_reg; div_lim = LIM_90;
            end
            J_ROOT:  sq_n = su2_reg;
            J_LEN:   sq_n = sp2_reg;
            J_MM:    sq_n = sm2_reg;
            default: ;
        endcase
    end

    egsp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && cmd.op == OP_MUL),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    egsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && cmd.op == OP_DIV),
        .n       (div_n),
        .k       (div_k),
        .d       (div_d),
        .lim     (div_lim),
        .done    (div_done),
        .q       (div_q)
    );

    egsp_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && cmd.op == OP_SQRT),
        .n       (sq_n),
        .done    (sq_done),
        .r       (sq_r)
    );

    always_comb begin
        r2_ext = {18'd0, r2_reg[ax]};
        sq40   = sw2_reg[127:40];
        o_mag  = tmp_reg[127:40];
        mag    = (o_mag > {40'd0, OUT_MAX}) ? OUT_MAX : o_mag[47:0];
        am_w   = {1'b0, am_reg} + {1'b0, stp_reg};

        rad_next     = rad_reg;
        pm_next      = pm_reg;
        pn_next      = pn_reg;
        rr_next      = rr_reg;
        r2_next      = r2_reg;
        pr_next      = pr_reg;
        wm_next      = wm_reg;
        work_next    = work_reg;
        tmp_next     = tmp_reg;
        u2_next      = u2_reg;
        sp2_next     = sp2_reg;
        su2_next     = su2_reg;
        sm2_next     = sm2_reg;
        sw2_next     = sw2_reg;
        g_next       = g_reg;
        root_next    = root_reg;
        len_next     = len_reg;
        mm_next      = mm_reg;
        diff_next    = diff_reg;
        aneg_next    = aneg_reg;
        sneg_next    = sneg_reg;
        am_next      = am_reg;
        stp_next     = stp_reg;
        e_next       = e_reg;
        smag_next    = smag_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        if (cfg_valid) begin
            case (cfg_index)
                REG_RADIUS_X: rad_next[0] = cfg_data;
                REG_RADIUS_Y: rad_next[1] = cfg_data;
                REG_RADIUS_Z: rad_next[2] = cfg_data;
                default: ;
            endcase
        end

        case (cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    pn_next[i] = pt[i][47];
                    pm_next[i] = pt[i][47] ? (~pt[i] + 48'd1) : pt[i];
                    if (rad_reg[i] < RAD_MIN)      rr_next[i] = RAD_MIN;
                    else if (rad_reg[i] > RAD_MAX) rr_next[i] = RAD_MAX;
                    else                           rr_next[i] = rad_reg[i];
                end
                sp2_next = '0;
                su2_next = '0;
                sm2_next = '0;
            end
            OP_ZERO: begin
                for (int i = 0; i < 3; i++) work_next[i] = '0;
            end
            OP_MUL: begin
                if (mul_done) begin
                    case (cmd.job)
                        J_R2: r2_next[ax] = mul_p[72:0];
                        J_PR: pr_next[ax] = mul_p[83:0];
                        J_P2: begin tmp_next = mul_p; sp2_next = sp2_reg + mul_p; end
                        J_W2: begin tmp_next = mul_p; sw2_next = sw2_reg + mul_p; end
                        default: tmp_next = mul_p;
                    endcase
                end
            end
            OP_DIV: begin
                if (div_done) begin
                    case (cmd.job)
                        J_U2:  begin u2_next = div_q; su2_next = su2_reg + div_q; end
                        J_M2:  sm2_next = sm2_reg + div_q;
                        J_AM:  am_next = div_q[90:0];
                        J_W:   wm_next[ax] = div_q[62:0];
                        J_G:   g_next = g_reg + div_q;
                        default: stp_next = div_q[90:0];
                    endcase
                end
            end
            OP_SQRT: begin
                if (sq_done) begin
                    case (cmd.job)
                        J_ROOT:  root_next = sq_r;
                        J_LEN:   len_next = sq_r;
                        default: mm_next = (sq_r == 64'd0) ? 64'd1 : sq_r;
                    endcase
                end
            end
            OP_DIFF: begin
                if (root_reg >= ONE_Q30) begin
                    aneg_next = 1'b0;
                    diff_next = root_reg - ONE_Q30;
                end else begin
                    aneg_next = 1'b1;
                    diff_next = ONE_Q30 - root_reg;
                end
            end
            OP_PASS: begin
                sw2_next = '0;
                g_next   = '0;
            end
            OP_DENOM: begin
                // non-positive denominator falls back to one LSB
                if (!aneg_reg)           e_next = {1'b0, r2_ext} + {1'b0, am_reg};
                else if (r2_ext > am_reg) e_next = {1'b0, r2_ext - am_reg};
                else                     e_next = 92'd1;
            end
            OP_RESID: begin
                if (sq40 >= ONE_Q40) begin
                    sneg_next = 1'b0;
                    smag_next = sq40 - ONE_Q40;
                end else begin
                    sneg_next = 1'b1;
                    smag_next = ONE_Q40 - sq40;
                end
            end
            OP_UPDATE: begin
                if (sneg_reg != aneg_reg) begin
                    if (am_reg >= stp_reg) begin
                        am_w = {1'b0, am_reg - stp_reg};
                    end else begin
                        am_w      = {1'b0, stp_reg - am_reg};
                        aneg_next = sneg_reg;
                    end
                end
                am_next = (am_w > {1'b0, ALPHA_MAX}) ? ALPHA_MAX : am_w[90:0];
            end
            OP_OUTAX: begin
                work_next[ax] = pn_reg[ax] ? (~mag + 48'd1) : mag;
            end
            OP_PUSH: begin
                out_next.surface_x = work_reg[0];
                out_next.surface_y = work_reg[1];
                out_next.surface_z = work_reg[2];
                out_next.status    = cmd.stat;
                m_valid_next       = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) rad_reg[i] <= RAD_MIN;
            m_valid_reg <= 1'b0;
        end else begin
            rad_reg     <= rad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pm_reg   <= pm_next;
        pn_reg   <= pn_next;
        rr_reg   <= rr_next;
        r2_reg   <= r2_next;
        pr_reg   <= pr_next;
        wm_reg   <= wm_next;
        work_reg <= work_next;
        tmp_reg  <= tmp_next;
        u2_reg   <= u2_next;
        sp2_reg  <= sp2_next;
        su2_reg  <= su2_next;
        sm2_reg  <= sm2_next;
        sw2_reg  <= sw2_next;
        g_reg    <= g_next;
        root_reg <= root_next;
        len_reg  <= len_next;
        mm_reg   <= mm_next;
        diff_reg <= diff_next;
        aneg_reg <= aneg_next;
        sneg_reg <= sneg_next;
        am_reg   <= am_next;
        stp_reg  <= stp_next;
        e_reg    <= e_next;
        smag_reg <= smag_next;
        out_reg  <= out_next;
    end

    assign sts.done     = mul_done | div_done | sq_done;
    assign sts.origin   = (pm_reg[0] == '0) && (pm_reg[1] == '0) && (pm_reg[2] == '0);
    assign sts.conv     = (smag_reg <= EPS_Q40);
    assign sts.out_full = m_valid_reg & ~m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;

endmodule

// ----- hw/rtl/egsp_ctrl.sv -----
module egsp_ctrl
    import egsp_pkg::*;
#(
    parameter int MAX_STEPS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  egsp_sts_t sts,
    output egsp_cmd_t cmd
);

    localparam int PASS_W = $clog2(MAX_STEPS + 1);

    egsp_state_t       state_reg, state_next;
    logic [1:0]        ax_reg, ax_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              launched_reg, launched_next;
    logic [1:0]        stat_reg, stat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ax_reg       <= 2'd0;
            pass_reg     <= '0;
            launched_reg <= 1'b0;
            stat_reg     <= STAT_CONV;
        end else begin
            state_reg    <= state_next;
            ax_reg       <= ax_next;
            pass_reg     <= pass_next;
            launched_reg <= launched_next;
            stat_reg     <= stat_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ax_next       = ax_reg;
        pass_next     = pass_reg;
        launched_next = launched_reg;
        stat_next     = stat_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.job       = J_R2;
        cmd.start     = 1'b0;
        cmd.axis      = ax_reg;
        cmd.stat      = stat_reg;

        // unit states: launch once, hold until the unit reports done; ST_STEP skips the launch when converged
        case (state_reg)
            ST_R2, ST_PR, ST_P2, ST_DL, ST_W2, ST_OMUL: cmd.op = OP_MUL;
            ST_U2, ST_M2, ST_AM, ST_W, ST_G, ST_STEP:   cmd.op = OP_DIV;
            ST_ROOT, ST_LEN, ST_MM:                     cmd.op = OP_SQRT;
            default: ;
        endcase
        if (cmd.op == OP_MUL || cmd.op == OP_DIV || cmd.op == OP_SQRT) begin
            cmd.start     = ~launched_reg;
            launched_next = 1'b1;
            if (sts.done) launched_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                ax_next   = 2'd0;
                pass_next = '0;
                if (sts.origin) begin
                    cmd.op     = OP_ZERO;
                    stat_next  = STAT_ORIGIN;
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_R2;
                end
            end
            ST_R2: begin
                cmd.job = J_R2;
                if (sts.done) state_next = ST_PR;
            end
            ST_PR: begin
                cmd.job = J_PR;
                if (sts.done) state_next = ST_P2;
            end
            ST_P2: begin
                cmd.job = J_P2;
                if (sts.done) state_next = ST_U2;
            end
            ST_U2: begin
                cmd.job = J_U2;
                if (sts.done) state_next = ST_M2;
            end
            ST_M2: begin
                cmd.job = J_M2;
                if (sts.done) begin
                    if (ax_reg == 2'd2) begin
                        ax_next    = 2'd0;
                        state_next = ST_ROOT;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_R2;
                    end
                end
            end
            ST_ROOT: begin
                cmd.job = J_ROOT;
                if (sts.done) state_next = ST_LEN;
            end
            ST_LEN: begin
                cmd.job = J_LEN;
                if (sts.done) state_next = ST_MM;
            end
            ST_MM: begin
                cmd.job = J_MM;
                if (sts.done) state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_DL;
            end
            ST_DL: begin
                cmd.job = J_DL;
                if (sts.done) state_next = ST_AM;
            end
            ST_AM: begin
                cmd.job = J_AM;
                if (sts.done) state_next = ST_PASS;
            end
            ST_PASS: begin
                cmd.op     = OP_PASS;
                ax_next    = 2'd0;
                state_next = ST_DENOM;
            end
            ST_DENOM: begin
                cmd.op     = OP_DENOM;
                state_next = ST_W;
            end
            ST_W: begin
                cmd.job = J_W;
                if (sts.done) state_next = ST_W2;
            end
            ST_W2: begin
                cmd.job = J_W2;
                if (sts.done) state_next = ST_G;
            end
            ST_G: begin
                cmd.job = J_G;
                if (sts.done) begin
                    if (ax_reg == 2'd2) begin
                        ax_next    = 2'd0;
                        state_next = ST_RESID;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_DENOM;
                    end
                end
            end
            ST_RESID: begin
                cmd.op     = OP_RESID;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.job = J_STP;
                if (sts.conv) begin
                    cmd.start     = 1'b0;
                    launched_next = 1'b0;
                    stat_next     = STAT_CONV;
                    state_next    = ST_OMUL;
                end else if (sts.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.op = OP_UPDATE;
                if (pass_reg == PASS_W'(MAX_STEPS - 1)) begin
                    stat_next  = STAT_LIMIT;
                    state_next = ST_OMUL;
                end else begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_PASS;
                end
            end
            ST_OMUL: begin
                cmd.job = J_OM;
                if (sts.done) state_next = ST_OWR;
            end
            ST_OWR: begin
                cmd.op = OP_OUTAX;
                if (ax_reg == 2'd2) begin
                    state_next = ST_PUSH;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_OMUL;
                end
            end
            ST_PUSH: begin
                if (!sts.out_full) begin
                    cmd.op     = OP_PUSH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/ellipsoid_geodetic_surface_projection_top.sv -----
// Projects a point along the ellipsoid normal onto the surface of an ellipsoid
// with three programmable semi-axes (Newton refinement of the normal offset).
// Channels: s_valid/s_ready/s_data carry one point (signed Q31.16 per axis);
// m_valid/m_ready/m_data return the surface point plus a status code
// (converged, pass limit reached, origin input). cfg_valid/cfg_ready/cfg_index/
// cfg_data write the radius registers (unsigned Q21.16); write them only while
// the block is idle. cfg_ready is always high.
// One point is processed at a time. Latency is set by the shared bit-serial
// divider, the square root and the 4-partial-product multiplier: a setup
// phase, then up to MAX_STEPS Newton passes; an origin input skips the
// arithmetic and goes from the check straight to the output register.
// The result sits in an output register: when the receiver stalls, the next
// point is still taken and computed, and only its final transfer waits until
// the previous result leaves. Reset (aresetn low, synchronous) returns the
// radii to 1.0, drops any pending result and idles the controller.
module ellipsoid_geodetic_surface_projection_top
    import egsp_pkg::*;
#(
    parameter int MAX_STEPS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [RAD_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  egsp_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output egsp_out_t        m_data
);

    egsp_cmd_t cmd;
    egsp_sts_t sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: steps the job list and the Newton passes
    egsp_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // operand registers, shared arithmetic units and output register
    egsp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
